/* rtl/tpe_pkg.sv */
// ----------------------------------------------------------------------------
// tpe_pkg: shared types and constants of the turning point extractor
// Holds item codes, result kinds, slope directions, queue sizing and the
// status records that pass between the front, the queue and the top level.
// ----------------------------------------------------------------------------
package tpe_pkg;

	localparam int SAMPLE_BITS_DEF = 12;
	localparam int TIME_BITS_DEF   = 16;
	localparam int DATA_BITS       = 32;
	localparam int ADDR_BITS       = 3;
	localparam int CTRL_BITS       = 3;   // point_kind plus is_last
	localparam int QUEUE_DEPTH     = 4;   // power of two
	localparam int QPTR_BITS       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS       = $clog2(QUEUE_DEPTH + 1);

	// register index, taken from paddr[2]
	localparam logic REG_DEADBAND = 1'b0;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_FINISH = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		KIND_FIRST = 2'd0,
		KIND_TURN  = 2'd1,
		KIND_FINAL = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		DIR_NONE   = 2'd0,
		DIR_VALLEY = 2'd1,
		DIR_PEAK   = 2'd2
	} dir_t;

	typedef struct packed {
		logic       fire;
		logic [1:0] count;   // results produced by the accepted item
	} push_t;

	typedef struct packed {
		logic room;          // space for a full two-result burst
		logic nonempty;
	} qstat_t;

	typedef struct packed {
		logic [1:0] fill;
		logic       pend_valid;
	} fstat_t;

endpackage

/* rtl/tpe_front.sv */
// ----------------------------------------------------------------------------
// tpe_front: sample window, turning point classification and pending point
// Takes one item per transfer, updates the three-point window and produces
// zero, one or two result words for the queue in the same cycle.
// ----------------------------------------------------------------------------
module tpe_front import tpe_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int TIME_BITS   = TIME_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic [SAMPLE_BITS-1:0]                   deadband,
	input  logic                                     fire,
	input  logic                                     op,
	input  logic [SAMPLE_BITS-1:0]                   sample,
	output push_t                                    push,
	output logic [TIME_BITS+SAMPLE_BITS+CTRL_BITS-1:0] res0,
	output logic [TIME_BITS+SAMPLE_BITS+CTRL_BITS-1:0] res1,
	output fstat_t                                   stat
);

	localparam int RW = TIME_BITS + SAMPLE_BITS + CTRL_BITS;

	logic [SAMPLE_BITS-1:0] amp0_q, amp1_q, pend_amp_q;
	logic [TIME_BITS-1:0]   time0_q, time1_q, pend_delta_q, count_q, last_rep_q;
	logic [1:0]             fill_q;
	dir_t                   dir_q;
	logic                   pend_valid_q;

	logic [SAMPLE_BITS-1:0] amp0_d, amp1_d, pend_amp_d;
	logic [TIME_BITS-1:0]   time0_d, time1_d, pend_delta_d, count_d, last_rep_d;
	logic [1:0]             fill_d;
	dir_t                   dir_d;
	logic                   pend_valid_d;

	logic [SAMPLE_BITS-1:0] prev_amp, diff, fin_amp;
	logic [TIME_BITS-1:0]   fin_time, fin_delta, turn_delta;
	logic                   in_band, up01, up12;
	dir_t                   turn_dir;
	logic [1:0]             n_res;
	logic [RW-1:0]          r0, r1;

	function automatic logic [RW-1:0] pack(input logic [TIME_BITS-1:0] delta,
			input logic [SAMPLE_BITS-1:0] amp, input kind_t kind, input logic last);
		pack = {delta, amp, kind, last};
	endfunction

	// newest kept point
	assign prev_amp  = (fill_q == 2'd2) ? amp1_q : amp0_q;
	assign diff      = (sample >= prev_amp) ? (sample - prev_amp) : (prev_amp - sample);
	assign in_band   = diff < deadband;
	assign fin_amp   = (fill_q == 2'd2) ? amp1_q : amp0_q;
	assign fin_time  = (fill_q == 2'd2) ? time1_q : time0_q;
	assign fin_delta = (fill_q == 2'd0) ? '0 : (fin_time - last_rep_q);

	// flat steps count as falling
	assign up01       = amp0_q < amp1_q;
	assign up12       = amp1_q < sample;
	assign turn_dir   = up01 ? DIR_PEAK : DIR_VALLEY;
	assign turn_delta = time1_q - last_rep_q;

	always_comb begin
		amp0_d       = amp0_q;
		amp1_d       = amp1_q;
		time0_d      = time0_q;
		time1_d      = time1_q;
		fill_d       = fill_q;
		dir_d        = dir_q;
		count_d      = count_q + TIME_BITS'(1);
		last_rep_d   = last_rep_q;
		pend_amp_d   = pend_amp_q;
		pend_delta_d = pend_delta_q;
		pend_valid_d = pend_valid_q;
		n_res        = 2'd0;
		r0           = '0;
		r1           = '0;
		if (op == OP_FINISH) begin
			// flush the held turning point, then the newest sample, then clear
			if (pend_valid_q) begin
				r0    = pack(pend_delta_q, pend_amp_q, KIND_TURN, 1'b0);
				r1    = pack(fin_delta, fin_amp, KIND_FINAL, 1'b1);
				n_res = 2'd2;
			end else begin
				r0    = pack(fin_delta, fin_amp, KIND_FINAL, 1'b1);
				n_res = 2'd1;
			end
			if (fill_q == 2'd0) begin
				r0[CTRL_BITS +: SAMPLE_BITS] = pend_valid_q ? pend_amp_q : '0;
			end
			fill_d       = 2'd0;
			dir_d        = DIR_NONE;
			count_d      = '0;
			last_rep_d   = '0;
			pend_valid_d = 1'b0;
		end else if (fill_q == 2'd0) begin
			amp0_d  = sample;
			time0_d = count_q;
			fill_d  = 2'd1;
			r0      = pack(count_q, sample, KIND_FIRST, 1'b0);
			n_res   = 2'd1;
		end else if (in_band) begin
			if (fill_q == 2'd2) begin
				amp1_d  = sample;
				time1_d = count_q;
			end else begin
				amp0_d  = sample;
				time0_d = count_q;
			end
		end else if (fill_q == 2'd1) begin
			amp1_d  = sample;
			time1_d = count_q;
			fill_d  = 2'd2;
		end else if (up01 != up12) begin
			if (pend_valid_q && (turn_dir == dir_q)) begin
				pend_delta_d = pend_delta_q + turn_delta;
			end else begin
				if (pend_valid_q) begin
					r0    = pack(pend_delta_q, pend_amp_q, KIND_TURN, 1'b0);
					n_res = 2'd1;
				end
				pend_delta_d = turn_delta;
			end
			pend_amp_d   = amp1_q;
			pend_valid_d = 1'b1;
			last_rep_d   = time1_q;
			dir_d        = turn_dir;
			amp0_d       = sample;
			time0_d      = count_q;
			fill_d       = 2'd1;
		end else begin
			amp0_d  = amp1_q;
			time0_d = time1_q;
			amp1_d  = sample;
			time1_d = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= 2'd0;
			dir_q        <= DIR_NONE;
			count_q      <= '0;
			last_rep_q   <= '0;
			pend_valid_q <= 1'b0;
		end else if (fire) begin
			fill_q       <= fill_d;
			dir_q        <= dir_d;
			count_q      <= count_d;
			last_rep_q   <= last_rep_d;
			pend_valid_q <= pend_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			amp0_q       <= amp0_d;
			amp1_q       <= amp1_d;
			time0_q      <= time0_d;
			time1_q      <= time1_d;
			pend_amp_q   <= pend_amp_d;
			pend_delta_q <= pend_delta_d;
		end
	end

	assign push.fire       = fire;
	assign push.count      = n_res;
	assign res0            = r0;
	assign res1            = r1;
	assign stat.fill       = fill_q;
	assign stat.pend_valid = pend_valid_q;

endmodule

/* rtl/tpe_queue.sv */
// ----------------------------------------------------------------------------
// tpe_queue: short result queue between front and back
// Takes up to two result words per cycle and hands out one per cycle while pop is asserted.
// ----------------------------------------------------------------------------
module tpe_queue import tpe_pkg::*; #(
	parameter int RW = TIME_BITS_DEF + SAMPLE_BITS_DEF + CTRL_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  push_t         push,
	input  logic [RW-1:0] wdata0,
	input  logic [RW-1:0] wdata1,
	input  logic          pop,
	output logic [RW-1:0] rdata,
	output qstat_t        stat
);

	logic [RW-1:0]        slot_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] head_q, tail_q, tail_nx;
	logic [QCNT_BITS-1:0] cnt_q, n_push, n_pop;

	assign n_push  = push.fire ? QCNT_BITS'(push.count) : '0;
	assign n_pop   = pop ? QCNT_BITS'(1) : '0;
	assign tail_nx = tail_q + QPTR_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			tail_q <= tail_q + QPTR_BITS'(n_push);
			if (pop) begin
				head_q <= head_q + QPTR_BITS'(1);
			end
			cnt_q <= cnt_q + n_push - n_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (push.fire && (push.count != 2'd0)) begin
			slot_q[tail_q] <= wdata0;
		end
		if (push.fire && (push.count == 2'd2)) begin
			slot_q[tail_nx] <= wdata1;
		end
	end

	assign rdata         = slot_q[head_q];
	assign stat.nonempty = cnt_q != '0;
	assign stat.room     = cnt_q <= QCNT_BITS'(QUEUE_DEPTH - 2);

endmodule

/* rtl/tpe_back.sv */
// ----------------------------------------------------------------------------
// tpe_back: result output register
// Loads the queue head whenever the queue is nonempty and the output is empty or being taken.
// ----------------------------------------------------------------------------
module tpe_back import tpe_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int TIME_BITS   = TIME_BITS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  qstat_t                                     qstat,
	input  logic [TIME_BITS+SAMPLE_BITS+CTRL_BITS-1:0] qdata,
	output logic                                       pop,
	output logic                                       out_valid,
	input  logic                                       out_ready,
	output logic [TIME_BITS-1:0]                       time_delta,
	output logic [SAMPLE_BITS-1:0]                     amplitude,
	output logic [1:0]                                 point_kind,
	output logic                                       is_last
);

	logic                   valid_q;
	logic [TIME_BITS-1:0]   delta_q;
	logic [SAMPLE_BITS-1:0] amp_q;
	logic [1:0]             kind_q;
	logic                   last_q;

	assign pop = qstat.nonempty && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || out_ready) begin
			valid_q <= qstat.nonempty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			{delta_q, amp_q, kind_q, last_q} <= qdata;
		end
	end

	assign out_valid  = valid_q;
	assign time_delta = delta_q;
	assign amplitude  = amp_q;
	assign point_kind = kind_q;
	assign is_last    = last_q;

endmodule

/* rtl/turning_point_extractor.sv */
// ----------------------------------------------------------------------------
// turning_point_extractor: peak and valley detector with deadband
// Reduces a stream of ADC samples to its first sample, its turning points
// and its final sample, each with the ticks since the last reported point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, op, sample): one item per transfer,
//   op selects a new sample or a finish. Output channel (out_valid/out_ready,
//   time_delta, amplitude, point_kind, is_last): one result per transfer.
//   Configuration: APB-style port, deadband at byte address 0; write it only
//   while the block is idle.
//   Throughput: one item per cycle while the output keeps taking results;
//   a finish with a pending turning point yields two results. The rate is
//   set by the single output register.
//   Result path: a result produced by an item is written into the queue when
//   the item transfers; the output register then loads it from the queue
//   once the register is empty or its result is being taken.
//   Reset: clears window, tick counter, pending point, queue and deadband.
//   Receiver stall: results hold in the output register and the four-entry
//   queue; in_ready drops once fewer than two queue slots are free.
// ----------------------------------------------------------------------------
module turning_point_extractor import tpe_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int TIME_BITS   = TIME_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [ADDR_BITS-1:0]   paddr,
	input  logic [DATA_BITS-1:0]   pwdata,
	output logic [DATA_BITS-1:0]   prdata,
	output logic                   pready,
	// items
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   op,
	input  logic [SAMPLE_BITS-1:0] sample,
	// results
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [TIME_BITS-1:0]   time_delta,
	output logic [SAMPLE_BITS-1:0] amplitude,
	output logic [1:0]             point_kind,
	output logic                   is_last
);

	localparam int RW = TIME_BITS + SAMPLE_BITS + CTRL_BITS;

	logic [SAMPLE_BITS-1:0] deadband_q;
	logic                   in_fire, pop;
	push_t                  push;
	qstat_t                 qstat;
	fstat_t                 fstat;
	logic [RW-1:0]          res0, res1, qdata;

	// Register port: no wait states; byte offset within a word is ignored.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= '0;
		end else if (psel && penable && pwrite && (paddr[2] == REG_DEADBAND)) begin
			deadband_q <= pwdata[SAMPLE_BITS-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_DEADBAND) ? DATA_BITS'(deadband_q) : '0;

	// Accept an item only when the queue can take a full two-result burst.
	assign in_ready = qstat.room;
	assign in_fire  = in_valid && in_ready;

	tpe_front #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.TIME_BITS  (TIME_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.deadband(deadband_q),
		.fire    (in_fire),
		.op      (op),
		.sample  (sample),
		.push    (push),
		.res0    (res0),
		.res1    (res1),
		.stat    (fstat)
	);

	tpe_queue #(
		.RW(RW)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata0(res0),
		.wdata1(res1),
		.pop   (pop),
		.rdata (qdata),
		.stat  (qstat)
	);

	tpe_back #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.TIME_BITS  (TIME_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.qdata     (qdata),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.time_delta(time_delta),
		.amplitude (amplitude),
		.point_kind(point_kind),
		.is_last   (is_last)
	);

	// A finish leaves the window empty and drops the pending point.
	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (op == OP_FINISH) |=> (fstat.fill == 2'd0) && !fstat.pend_valid)
		else $error("state not cleared after finish");

	// The window never rests with three points.
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fstat.fill != 2'd3)
		else $error("window left full");

	// A first sample always produces a result on the next cycle.
	a_first_emits: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (op == OP_SAMPLE) && (fstat.fill == 2'd0) |=> qstat.nonempty || out_valid)
		else $error("first sample produced no result");

	// The output only becomes valid from a queued result.
	a_out_from_queue: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(qstat.nonempty))
		else $error("output valid without queued result");

endmodule
